>>> rtl/wwsm_pkg.sv
// wwsm_pkg: shared sizes, the signature table and the types that pass between modules
// of the wildcard word signature matcher; depends on nothing
`timescale 1ns / 1ps

package wwsm_pkg;

    // table sizes
    localparam int NUM_SIG = 6;
    localparam int MAX_PW  = 8;

    // field widths
    localparam int WORD_W = 32;
    localparam int IDX_W  = 3;

    // word counter saturates at MAX_PW, table row index covers MAX_PW rows
    localparam int POS_W  = $clog2(MAX_PW + 1);
    localparam int PIDX_W = (MAX_PW > 1) ? $clog2(MAX_PW) : 1;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [NUM_SIG-1:0] t_mask;

    // per-sequence tracking state
    typedef struct packed {
        t_mask still;
        t_pos  pos;
    } t_track;

    // one result beat
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_result;

    localparam t_mask ALL_SIGS = {NUM_SIG{1'b1}};

    // nibble care masks
    localparam t_word EXACT  = 32'hFFFF_FFFF;
    localparam t_word WILD16 = 32'hFFFF_0000;
    localparam t_word WILD24 = 32'hFF00_0000;
    localparam t_word UNUSED = 32'h0000_0000;

    // signature lengths in words
    localparam t_pos SIG_LEN [NUM_SIG] = '{
        POS_W'(7), POS_W'(8), POS_W'(7), POS_W'(7), POS_W'(7), POS_W'(8)
    };

    // pattern values
    localparam t_word SIG_VALUE [NUM_SIG][MAX_PW] = '{
        '{32'h9421FF80, 32'h7C0802A6, 32'h90010000, 32'h40860024,
          32'hD8210028, 32'hD8410030, 32'hD8610038, 32'h00000000},
        '{32'h9421FFE0, 32'h7C0802A6, 32'h90010000, 32'h34010008,
          32'h93E10000, 32'h93C10000, 32'h3BC00000, 32'h93A10000},
        '{32'h9421FFC0, 32'h7C0802A6, 32'h90010000, 32'h39610000,
          32'h48000000, 32'h34010008, 32'h7C771B78, 32'h00000000},
        '{32'h9421FFD0, 32'h7C0802A6, 32'h90010000, 32'h39610000,
          32'h48000000, 32'h34010008, 32'h7C791B78, 32'h00000000},
        '{32'h9421FF90, 32'h7C0802A6, 32'h90010000, 32'h93E10000,
          32'h7CBF2B78, 32'h93C10000, 32'h7C9E2378, 32'h00000000},
        '{32'h9421FF90, 32'h7C0802A6, 32'h90010000, 32'h39610000,
          32'h48000000, 32'h7C7B1B78, 32'h7C9C2378, 32'h7CBD2B78}
    };

    // pattern care masks, a cleared nibble is a wildcard
    localparam t_word SIG_CARE [NUM_SIG][MAX_PW] = '{
        '{EXACT, EXACT, WILD16, EXACT,  EXACT,  EXACT,  EXACT,  UNUSED},
        '{EXACT, EXACT, WILD16, EXACT,  WILD16, WILD16, WILD16, WILD16},
        '{EXACT, EXACT, WILD16, WILD16, WILD24, EXACT,  EXACT,  UNUSED},
        '{EXACT, EXACT, WILD16, WILD16, WILD24, EXACT,  EXACT,  UNUSED},
        '{EXACT, EXACT, WILD16, WILD16, EXACT,  WILD16, EXACT,  UNUSED},
        '{EXACT, EXACT, WILD16, WILD16, WILD24, EXACT,  EXACT,  EXACT}
    };

endpackage

>>> rtl/wildcard_word_signature_matcher.sv
// A taken word is held in the input register and compared from there; a last word's result
// beat is loaded into the result register when that word is consumed, which sets o_valid.
// Throughput: one word per cycle, set by the single compare stage between the
// input register and the result register; a waiting result holds a last word in
// the input register, and the words behind it wait until the result is taken.
// Reset (synchronous, active low): empties both registers, all signatures back in
// play, word count zero. No clearing pass.
`timescale 1ns / 1ps

module wildcard_word_signature_matcher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [31:0]               i_instr_word,
    input  logic                      i_last_word,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_found,
    output logic [2:0]                o_signature_index
);

    // input register
    logic              r_in_valid;
    wwsm_pkg::t_word   r_in_word;
    logic              r_in_last;

    // sequence state
    wwsm_pkg::t_track  r_track;
    wwsm_pkg::t_track  n_track;

    // result register
    logic              r_out_valid;
    wwsm_pkg::t_result r_result;
    wwsm_pkg::t_result n_result;

    logic s_take;
    logic s_consume;

    // a last word needs a free result slot, any other word goes straight through
    assign s_consume = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || s_consume;
    assign s_take    = i_valid && o_ready;

    wwsm_cmp u_cmp (
        .i_word  (r_in_word),
        .i_track (r_track),
        .o_track (n_track)
    );

    wwsm_pick u_pick (
        .i_track  (n_track),
        .o_result (n_result)
    );

    // control and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_track.still <= wwsm_pkg::ALL_SIGS;
            r_track.pos   <= '0;
        end else begin
            if (s_take) begin
                r_in_valid <= 1'b1;
            end else if (s_consume) begin
                r_in_valid <= 1'b0;
            end
            if (s_consume && r_in_last) begin
                r_out_valid   <= 1'b1;
                r_track.still <= wwsm_pkg::ALL_SIGS;
                r_track.pos   <= '0;
            end else begin
                if (i_ready) begin
                    r_out_valid <= 1'b0;
                end
                if (s_consume) begin
                    r_track <= n_track;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_word <= i_instr_word;
            r_in_last <= i_last_word;
        end
        if (s_consume && r_in_last) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_found           = r_result.found;
    assign o_signature_index = r_result.idx;

endmodule

>>> rtl/wwsm_cmp.sv
// wwsm_cmp: compares one word against every signature row whose length reaches the current
// position and advances the word counter; depends on wwsm_pkg
`timescale 1ns / 1ps

module wwsm_cmp (
    input  wwsm_pkg::t_word  i_word,
    input  wwsm_pkg::t_track i_track,
    output wwsm_pkg::t_track o_track
);

    logic                        s_in_range;
    logic [wwsm_pkg::PIDX_W-1:0] s_row;

    assign s_in_range = (i_track.pos < wwsm_pkg::POS_W'(wwsm_pkg::MAX_PW));
    assign s_row      = i_track.pos[wwsm_pkg::PIDX_W-1:0];

    // drop every signature whose cared nibbles disagree with this word, where the word lies within its length
    always_comb begin
        for (int s = 0; s < wwsm_pkg::NUM_SIG; s++) begin
            o_track.still[s] = i_track.still[s];
            if (s_in_range && (i_track.pos < wwsm_pkg::SIG_LEN[s])) begin
                if (((i_word ^ wwsm_pkg::SIG_VALUE[s][s_row])
                     & wwsm_pkg::SIG_CARE[s][s_row]) != '0) begin
                    o_track.still[s] = 1'b0;
                end
            end
        end
    end

    // saturating word count, enough for the length test
    assign o_track.pos = s_in_range ? i_track.pos + wwsm_pkg::POS_W'(1) : i_track.pos;

endmodule

>>> rtl/wwsm_pick.sv
// wwsm_pick: length test and lowest-index priority pick that form the result beat;
// depends on wwsm_pkg
`timescale 1ns / 1ps

module wwsm_pick (
    input  wwsm_pkg::t_track  i_track,
    output wwsm_pkg::t_result o_result
);

    wwsm_pkg::t_mask s_hit;

    // a signature hits if it agreed with every word within its length and the sequence is long enough
    always_comb begin
        for (int s = 0; s < wwsm_pkg::NUM_SIG; s++) begin
            s_hit[s] = i_track.still[s] && (wwsm_pkg::SIG_LEN[s] <= i_track.pos);
        end
    end

    // lowest-numbered hit wins, scan from the top so lower indexes override
    always_comb begin
        o_result.found = 1'b0;
        o_result.idx   = '0;
        for (int s = wwsm_pkg::NUM_SIG - 1; s >= 0; s--) begin
            if (s_hit[s]) begin
                o_result.found = 1'b1;
                o_result.idx   = wwsm_pkg::IDX_W'(s);
            end
        end
    end

endmodule

>>> rtl/wwsm_chk.sv
// wwsm_chk: port-level assertions for the matcher, bound to the top level;
// depends on wwsm_pkg and wildcard_word_signature_matcher
`timescale 1ns / 1ps

module wwsm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_instr_word,
    input logic        i_last_word,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [2:0]  o_signature_index
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_signature_index))
        else $error("result beat changed while stalled");

    // no match reports index zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_signature_index == 3'd0)
        else $error("index not zero without a match");

    // a match names a real table row
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> int'(o_signature_index) < wwsm_pkg::NUM_SIG)
        else $error("signature index out of table");

    // nothing pending right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat shown after reset");

endmodule

bind wildcard_word_signature_matcher wwsm_chk u_wwsm_chk (.*);
